/* hdl/mcds_pkg.sv */
`default_nettype none
package mcds_pkg;

  localparam int SEED_W    = 31;
  localparam int OUT_CNT_W = 16;
  localparam int MUL_W     = 31;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int ACC_W     = 96;
  localparam int ADDR_W    = 4;
  localparam int NUM_DRAWS = 9;
  localparam int STEP_W    = 5;
  localparam int DET_OPS   = 18;

  localparam logic [SEED_W-1:0] LEHMER_MOD   = 31'h7FFF_FFFF;
  localparam logic [SEED_W-1:0] LEHMER_MUL   = 31'd48271;
  localparam logic [SEED_W-1:0] SEED_DEFAULT = 31'd123456789;

  // multiplier pass kinds in the determinant phase
  localparam logic [1:0] K_NONE = 2'd0;  // no pass
  localparam logic [1:0] K_AB   = 2'd1;  // a * b
  localparam logic [1:0] K_LO   = 2'd2;  // low half of a*b times c
  localparam logic [1:0] K_HI   = 2'd3;  // high half of a*b times c

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic              to_minus;
  } det_op_t;

  // schedule of the six triple products, three passes each
  function automatic det_op_t det_op(input logic [STEP_W-1:0] step);
    det_op_t op;
    op = '0;
    op.kind = K_NONE;
    case (step)
      5'd0:  begin op.kind = K_AB; op.addr_a = 4'd0; op.addr_b = 4'd4; end
      5'd1:  begin op.kind = K_LO; op.addr_b = 4'd8; end
      5'd2:  begin op.kind = K_HI; op.addr_b = 4'd8; end
      5'd3:  begin op.kind = K_AB; op.addr_a = 4'd0; op.addr_b = 4'd5; op.to_minus = 1'b1; end
      5'd4:  begin op.kind = K_LO; op.addr_b = 4'd7; op.to_minus = 1'b1; end
      5'd5:  begin op.kind = K_HI; op.addr_b = 4'd7; op.to_minus = 1'b1; end
      5'd6:  begin op.kind = K_AB; op.addr_a = 4'd1; op.addr_b = 4'd3; op.to_minus = 1'b1; end
      5'd7:  begin op.kind = K_LO; op.addr_b = 4'd8; op.to_minus = 1'b1; end
      5'd8:  begin op.kind = K_HI; op.addr_b = 4'd8; op.to_minus = 1'b1; end
      5'd9:  begin op.kind = K_AB; op.addr_a = 4'd1; op.addr_b = 4'd5; op.to_minus = 1'b1; end
      5'd10: begin op.kind = K_LO; op.addr_b = 4'd6; op.to_minus = 1'b1; end
      5'd11: begin op.kind = K_HI; op.addr_b = 4'd6; op.to_minus = 1'b1; end
      5'd12: begin op.kind = K_AB; op.addr_a = 4'd2; op.addr_b = 4'd3; op.to_minus = 1'b1; end
      5'd13: begin op.kind = K_LO; op.addr_b = 4'd7; op.to_minus = 1'b1; end
      5'd14: begin op.kind = K_HI; op.addr_b = 4'd7; op.to_minus = 1'b1; end
      5'd15: begin op.kind = K_AB; op.addr_a = 4'd2; op.addr_b = 4'd4; op.to_minus = 1'b1; end
      5'd16: begin op.kind = K_LO; op.addr_b = 4'd6; op.to_minus = 1'b1; end
      5'd17: begin op.kind = K_HI; op.addr_b = 4'd6; op.to_minus = 1'b1; end
      default: op.kind = K_NONE;
    endcase
    return op;
  endfunction

endpackage
`default_nettype wire

/* hdl/mcds_in_if.sv */
`default_nettype none
interface mcds_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
  modport monitor (input valid, input restart, input ready);
endinterface
`default_nettype wire

/* hdl/mcds_out_if.sv */
`default_nettype none
interface mcds_out_if;
  logic                           valid;
  logic                           ready;
  logic                           det_positive;
  logic [mcds_pkg::OUT_CNT_W-1:0] positive_count;
  logic [mcds_pkg::SEED_W-1:0]    current_seed;

  modport source (output valid, output det_positive, output positive_count,
                  output current_seed, input ready);
  modport sink (input valid, input det_positive, input positive_count,
                input current_seed, output ready);
  modport monitor (input valid, input det_positive, input positive_count,
                   input current_seed, input ready);
endinterface
`default_nettype wire

/* hdl/monte_carlo_det_sign_counter_unit.sv */
`default_nettype none
// Monte Carlo determinant-sign counter. Each input transaction runs one
// replication: if restart is set the generator reloads from start_seed (a seed
// equal to 2^31-1 loads 0) and the hit count clears; the Lehmer generator
// (48271 * s mod 2^31-1) is then stepped nine times to fill a 3x3 matrix with
// negated off-diagonal entries, the determinant sign is found exactly, and a
// saturating COUNT_BITS-wide counter counts strictly positive results. One
// result transaction follows each input transaction, carrying the sign, the
// low 16 bits of the count and the generator state after the nine draws.
// All multiplications go through one shared 31x31 multiplier: each draw has a
// multiply state and a fold state, the six triple products take three
// multiplier passes each through a read/multiply/accumulate pipe that is
// drained at the end, and a finish state compares and updates the count.
// in_ch.ready rises in the same cycle as out_ch.valid, so the block takes one
// item at a time and accepts the next once its result is registered; the
// compare state waits while an older result is still unaccepted, and the
// result register lets the next item be accepted while a result waits.
module monte_carlo_det_sign_counter_unit #(
  parameter int COUNT_BITS = 16
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_we,
  input  wire [mcds_pkg::SEED_W-1:0]   cfg_wdata,
  mcds_in_if.sink                      in_ch,
  mcds_out_if.source                   out_ch
);

  localparam int SeedW   = mcds_pkg::SEED_W;
  localparam int MulW    = mcds_pkg::MUL_W;
  localparam int ProdW   = mcds_pkg::PROD_W;
  localparam int AccW    = mcds_pkg::ACC_W;
  localparam int AddrW   = mcds_pkg::ADDR_W;
  localparam int StepW   = mcds_pkg::STEP_W;
  localparam int CntOutW = mcds_pkg::OUT_CNT_W;

  // sequencer states
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DRAW_MUL = 3'd1;
  localparam logic [2:0] ST_DRAW_RED = 3'd2;
  localparam logic [2:0] ST_DET      = 3'd3;
  localparam logic [2:0] ST_FINISH   = 3'd4;

  localparam logic [AddrW-1:0] LastDraw = AddrW'(mcds_pkg::NUM_DRAWS - 1);
  localparam logic [StepW-1:0] LastStep = StepW'(mcds_pkg::DET_OPS + 1);

  logic [2:0]            state_r, state_nxt;
  logic [SeedW-1:0]      cfg_seed_r;
  logic [SeedW-1:0]      gen_r, gen_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [AddrW-1:0]      draw_r, draw_nxt;
  logic [StepW-1:0]      step_r, step_nxt;

  // matrix entries, one per draw
  logic [SeedW-1:0] s_mem [mcds_pkg::NUM_DRAWS];

  // determinant pipe: read stage, multiply stage, accumulate
  mcds_pkg::det_op_t op;
  logic [1:0]        kind1_r;
  logic              minus1_r;
  logic [MulW-1:0]   rd_a_r, rd_b_r;
  logic [MulW-1:0]   ab_hi_r;
  logic [ProdW-1:0]  p_r;
  logic              add2_r, shift2_r, minus2_r;
  logic [AccW-1:0]   plus_r, minus_r;
  logic [AccW-1:0]   addend;

  logic [MulW-1:0]   mul_a, mul_b;
  logic [ProdW-1:0]  mul_p;

  logic [SeedW:0]    fold_sum;
  logic [SeedW-1:0]  fold_val;
  logic [SeedW-1:0]  load_seed;
  logic              det_pos;
  logic              in_acc, finish_go;

  logic                out_valid_r, out_valid_nxt;
  logic                out_pos_r;
  logic [CntOutW-1:0]  out_cnt_r;
  logic [SeedW-1:0]    out_seed_r;

  assign in_ch.ready           = (state_r == ST_IDLE);
  assign in_acc                = in_ch.valid & in_ch.ready;
  assign finish_go             = (state_r == ST_FINISH) & (~out_valid_r | out_ch.ready);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.det_positive   = out_pos_r;
  assign out_ch.positive_count = out_cnt_r;
  assign out_ch.current_seed   = out_seed_r;

  // restart load, a seed equal to the modulus folds to zero
  assign load_seed = (cfg_seed_r == mcds_pkg::LEHMER_MOD) ? '0 : cfg_seed_r;

  // fold 48271*s mod 2^31-1: high bits wrap around onto the low 31 bits,
  // the sum stays below twice the modulus so one subtract finishes it
  assign fold_sum = {1'b0, p_r[SeedW-1:0]} + (SeedW + 1)'(p_r[ProdW-1:SeedW]);
  assign fold_val = (fold_sum >= {1'b0, mcds_pkg::LEHMER_MOD})
                    ? SeedW'(fold_sum - {1'b0, mcds_pkg::LEHMER_MOD})
                    : fold_sum[SeedW-1:0];

  assign op = mcds_pkg::det_op(step_r);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == ST_DRAW_MUL) begin
      mul_a = mcds_pkg::LEHMER_MUL;
      mul_b = gen_r;
    end else begin
      case (kind1_r)
        mcds_pkg::K_AB: begin
          mul_a = rd_a_r;
          mul_b = rd_b_r;
        end
        mcds_pkg::K_LO: begin
          mul_a = p_r[MulW-1:0];
          mul_b = rd_b_r;
        end
        mcds_pkg::K_HI: begin
          mul_a = ab_hi_r;
          mul_b = rd_b_r;
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
  end

  assign mul_p  = ProdW'(mul_a) * ProdW'(mul_b);
  assign addend = shift2_r ? AccW'({p_r, {MulW{1'b0}}}) : AccW'(p_r);
  assign det_pos = plus_r > minus_r;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    gen_nxt       = gen_r;
    cnt_nxt       = cnt_r;
    draw_nxt      = draw_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r & ~out_ch.ready;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.restart) begin
            gen_nxt = load_seed;
            cnt_nxt = '0;
          end
          draw_nxt  = '0;
          state_nxt = ST_DRAW_MUL;
        end
      end
      ST_DRAW_MUL: begin
        state_nxt = ST_DRAW_RED;
      end
      ST_DRAW_RED: begin
        gen_nxt = fold_val;
        if (draw_r == LastDraw) begin
          step_nxt  = '0;
          state_nxt = ST_DET;
        end else begin
          draw_nxt  = draw_r + 1'b1;
          state_nxt = ST_DRAW_MUL;
        end
      end
      ST_DET: begin
        // last two steps drain the multiply and accumulate stages
        step_nxt = step_r + 1'b1;
        if (step_r == LastStep) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (finish_go) begin
          if (det_pos && (cnt_r != '1)) begin
            cnt_nxt = cnt_r + 1'b1;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_seed_r  <= mcds_pkg::SEED_DEFAULT;
      gen_r       <= mcds_pkg::SEED_DEFAULT;
      cnt_r       <= '0;
      draw_r      <= '0;
      step_r      <= '0;
      kind1_r     <= mcds_pkg::K_NONE;
      add2_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gen_r       <= gen_nxt;
      cnt_r       <= cnt_nxt;
      draw_r      <= draw_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cfg_seed_r <= cfg_wdata;
      end
      kind1_r <= (state_r == ST_DET) ? op.kind : mcds_pkg::K_NONE;
      add2_r  <= (kind1_r == mcds_pkg::K_LO) || (kind1_r == mcds_pkg::K_HI);
    end
  end

  // draw store and its two registered read ports
  always_ff @(posedge clk) begin
    if (state_r == ST_DRAW_RED) begin
      s_mem[draw_r] <= fold_val;
    end
    rd_a_r <= s_mem[op.addr_a];
    rd_b_r <= s_mem[op.addr_b];
  end

  // multiply and accumulate datapath
  always_ff @(posedge clk) begin
    minus1_r <= op.to_minus;
    p_r      <= mul_p;
    shift2_r <= (kind1_r == mcds_pkg::K_HI);
    minus2_r <= minus1_r;
    if (kind1_r == mcds_pkg::K_LO) begin
      ab_hi_r <= p_r[ProdW-1:MulW];
    end
    if (in_acc) begin
      plus_r  <= '0;
      minus_r <= '0;
    end else if (add2_r) begin
      if (minus2_r) begin
        minus_r <= minus_r + addend;
      end else begin
        plus_r <= plus_r + addend;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (finish_go) begin
      out_pos_r  <= det_pos;
      out_cnt_r  <= CntOutW'(cnt_nxt);
      out_seed_r <= gen_r;
    end
  end

endmodule
`default_nettype wire

/* hdl/mcds_checker.sv */
`default_nettype none
module mcds_checker (
  input wire                        clk,
  input wire                        rst_n,
  input wire                        in_valid,
  input wire                        in_ready,
  input wire                        out_valid,
  input wire                        out_ready,
  input wire [mcds_pkg::SEED_W-1:0] out_seed
);

  // a waiting result is not dropped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // generator state never reaches the modulus
  a_seed_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_seed != mcds_pkg::LEHMER_MOD)
    else $error("seed out of range");

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted while busy");

  // a new result only comes out of a busy period
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without work");

endmodule

bind monte_carlo_det_sign_counter_unit mcds_checker u_mcds_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_seed  (out_ch.current_seed)
);
`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  localparam int CNT_BITS    = 16;
  localparam int LIMIT       = 600000;
  localparam int HOLD_CYCLES = 400;

  // expected-result tracker for the determinant-sign counter
  class replication_ledger;
    typedef struct packed {
      logic                           pos;
      logic [mcds_pkg::OUT_CNT_W-1:0] count;
      logic [mcds_pkg::SEED_W-1:0]    seed;
    } outcome_t;

    outcome_t                    pending_results[$];
    logic [mcds_pkg::SEED_W-1:0] start_seed;
    logic [mcds_pkg::SEED_W-1:0] gen_state;
    logic [CNT_BITS-1:0]         hits;
    int                          errors;

    function new();
      start_seed = mcds_pkg::SEED_DEFAULT;
      gen_state  = mcds_pkg::SEED_DEFAULT;
      hits       = '0;
      errors     = 0;
    endfunction

    function void load_seed(logic [mcds_pkg::SEED_W-1:0] value);
      start_seed = value;
    endfunction

    function logic [mcds_pkg::SEED_W-1:0] lehmer_step(logic [mcds_pkg::SEED_W-1:0] s);
      logic [63:0] p;
      p = 64'(s) * 64'(mcds_pkg::LEHMER_MUL);
      return mcds_pkg::SEED_W'(p % 64'(mcds_pkg::LEHMER_MOD));
    endfunction

    function logic [127:0] triple(logic [mcds_pkg::SEED_W-1:0] a,
                                  logic [mcds_pkg::SEED_W-1:0] b,
                                  logic [mcds_pkg::SEED_W-1:0] c);
      return 128'(a) * 128'(b) * 128'(c);
    endfunction

    // one replication: nine draws, exact determinant sign, saturating count
    function void note_replication(logic restart);
      logic [mcds_pkg::SEED_W-1:0] s[9];
      logic [127:0]                plus;
      logic [127:0]                minus;
      outcome_t                    r;
      if (restart) begin
        gen_state = mcds_pkg::SEED_W'(64'(start_seed) % 64'(mcds_pkg::LEHMER_MOD));
        hits = '0;
      end
      for (int i = 0; i < 9; i++) begin
        gen_state = lehmer_step(gen_state);
        s[i] = gen_state;
      end
      plus  = triple(s[0], s[4], s[8]);
      minus = triple(s[0], s[5], s[7]) + triple(s[1], s[3], s[8]) +
              triple(s[1], s[5], s[6]) + triple(s[2], s[3], s[7]) +
              triple(s[2], s[4], s[6]);
      r.pos = (plus > minus);
      if (r.pos && hits != {CNT_BITS{1'b1}}) hits = hits + 1'b1;
      r.count = mcds_pkg::OUT_CNT_W'(hits);
      r.seed  = gen_state;
      pending_results.push_back(r);
    endfunction

    function void flag(string field, logic [63:0] want, logic [63:0] got);
      errors++;
      if (errors <= 10)
        $display("mismatch on %s: expected %0h, got %0h", field, want, got);
    endfunction

    function void check_result(logic pos, logic [mcds_pkg::OUT_CNT_W-1:0] count,
                               logic [mcds_pkg::SEED_W-1:0] seed);
      outcome_t want;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: pos %0h count %0h seed %0h", pos, count, seed);
        return;
      end
      want = pending_results.pop_front();
      if (want.pos !== pos) flag("det_positive", 64'(want.pos), 64'(pos));
      if (want.count !== count) flag("positive_count", 64'(want.count), 64'(count));
      if (want.seed !== seed) flag("current_seed", 64'(want.seed), 64'(seed));
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        cfg_we;
  logic [mcds_pkg::SEED_W-1:0] cfg_wdata;

  // when set, neither side inserts idle cycles
  logic steady = 1'b0;
  // asks the receiver for one long hold-off
  logic hold_request = 1'b0;

  replication_ledger ledger = new();

  mcds_in_if  in_ch ();
  mcds_out_if out_ch ();

  monte_carlo_det_sign_counter_unit #(
    .COUNT_BITS(CNT_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog on the whole run
  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  // sample both handshakes at the edge, input first so a prediction always precedes
  // its result
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) ledger.note_replication(in_ch.restart);
      if (out_ch.valid && out_ch.ready)
        ledger.check_result(out_ch.det_positive, out_ch.positive_count,
                            out_ch.current_seed);
    end
  end

  // result receiver: random back-pressure plus one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ch.ready <= steady || ($urandom_range(0, 99) >= 9);
      end
    end
  end

  // mostly legal seeds, sometimes any 31-bit pattern
  function automatic logic [mcds_pkg::SEED_W-1:0] rand_seed();
    if ($urandom_range(0, 3) == 0) return mcds_pkg::SEED_W'($urandom);
    return mcds_pkg::SEED_W'($urandom_range(32'h7FFF_FFFE, 1));
  endfunction

  // offer one replication request; returns at the edge where it is accepted
  task automatic offer_replication(input logic restart);
    if (!steady) begin
      while ($urandom_range(0, 99) < 9) begin
        in_ch.valid   <= 1'b0;
        in_ch.restart <= 1'($urandom_range(0, 1));
        @(posedge clk);
      end
    end
    in_ch.valid   <= 1'b1;
    in_ch.restart <= restart;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  // stop sending and wait until every predicted result has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (ledger.pending_results.size() != 0) @(posedge clk);
  endtask

  // only called while the block is idle
  task automatic load_start_seed(input logic [mcds_pkg::SEED_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    ledger.load_seed(value);
  endtask

  initial begin
    int phase;
    int k;
    int n;
    int restart_pct;

    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.restart <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset seed, then a restart back to the reset value
    offer_replication(1'b0);
    offer_replication(1'b0);
    offer_replication(1'b0);
    offer_replication(1'b1);

    // smallest and largest legal seeds
    drain_results();
    load_start_seed(31'd1);
    offer_replication(1'b1);
    offer_replication(1'b0);
    drain_results();
    load_start_seed(31'h7FFF_FFFE);
    offer_replication(1'b1);
    offer_replication(1'b0);

    // seed equal to the modulus folds to zero and the generator sticks there
    drain_results();
    load_start_seed(mcds_pkg::LEHMER_MOD);
    offer_replication(1'b1);
    offer_replication(1'b0);
    offer_replication(1'b0);
    // zero seed sticks as well
    drain_results();
    load_start_seed('0);
    offer_replication(1'b1);
    offer_replication(1'b0);

    // alternating bit patterns, then the default seed again
    drain_results();
    load_start_seed(31'h2AAA_AAAA);
    offer_replication(1'b1);
    drain_results();
    load_start_seed(31'h5555_5555);
    offer_replication(1'b1);
    drain_results();
    load_start_seed(mcds_pkg::SEED_DEFAULT);
    offer_replication(1'b1);
    offer_replication(1'b0);

    // long run without restart so the count climbs
    drain_results();
    load_start_seed(rand_seed());
    offer_replication(1'b1);
    for (n = 0; n < 200; n++) begin
      offer_replication(1'b0);
    end
    // a restart must clear a running count
    offer_replication(1'b1);
    offer_replication(1'b0);

    // random phases, each with a fresh seed and its own restart density
    for (phase = 0; phase < 20; phase++) begin
      drain_results();
      case (phase % 6)
        0: load_start_seed(31'h7FFF_FFFE);
        5: load_start_seed(mcds_pkg::SEED_W'($urandom));
        default: load_start_seed(rand_seed());
      endcase
      steady = (phase == 3);
      case (phase % 4)
        0: restart_pct = 0;
        1: restart_pct = 5;
        2: restart_pct = 30;
        default: restart_pct = 70;
      endcase
      offer_replication($urandom_range(0, 9) != 0);
      for (k = 0; k < 49; k++) begin
        // receiver holds off while the sender keeps pushing
        if (phase == 7 && k == 10) hold_request = 1'b1;
        // sender pauses mid-phase until everything is back
        if (phase == 12 && k == 25) drain_results();
        offer_replication($urandom_range(0, 99) < restart_pct);
      end
    end
    steady = 1'b0;

    drain_results();
    repeat (80) @(posedge clk);
    if (ledger.errors == 0 && ledger.pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      if (ledger.pending_results.size() != 0)
        $display("%0d results never arrived", ledger.pending_results.size());
      if (ledger.errors > 10)
        $display("%0d mismatches in total", ledger.errors);
      $display("FAILURE");
    end
    $finish;
  end
endmodule

/* filelist.f */
hdl/mcds_pkg.sv
hdl/mcds_in_if.sv
hdl/mcds_out_if.sv
hdl/monte_carlo_det_sign_counter_unit.sv
hdl/mcds_checker.sv
test/testbench.sv
